// ===== rtl/b64d_pkg.sv =====
// Shared types, constants and the symbol lookup for the base64 stream decoder.
// No dependencies.
`default_nettype none

package b64d_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned SymW   = 6;
  localparam int unsigned LenW   = 16;
  localparam int unsigned OutDataW = 32;

  localparam logic [CharW-1:0] PadChar   = 8'h3D;
  localparam logic [LenW-1:0]  MaxLenRst = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_RUN        = 2'd0,
    ST_OK         = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_OVERFLOW   = 2'd3
  } status_t;

  // Symbol lookup: bit 6 marks a character outside the alphabet, bits 5:0 the value.
  function automatic logic [SymW:0] sym_lookup(input logic [CharW-1:0] c);
    logic [SymW:0] r;
    r = 7'h40;
    if (c inside {[8'h41:8'h5A]}) begin
      r = {1'b0, 6'(c - 8'h41)};
    end else if (c inside {[8'h61:8'h7A]}) begin
      r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    end else if (c inside {[8'h30:8'h39]}) begin
      r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    end else if (c == 8'h2B) begin
      r = {1'b0, 6'd62};
    end else if (c == 8'h2F) begin
      r = {1'b0, 6'd63};
    end else if (c == PadChar) begin
      r = {1'b0, 6'd0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/base64_stream_decoder.sv =====
// Base64 stream decoder top level: input register, group decode, result buffer.
// Depends on b64d_pkg.
//
// Channel | Dir | tdata (low bit up)                           | tuser      | tlast
// s_*     | in  | in_char[7:0]                                 | -          | end_of_input
// m_*     | out | out_byte[7:0], msg_status[9:8], total_len[25:10], 0s | byte_valid | run_last
// cfg_*   | in  | cfg_wdata = max_out_len, written when cfg_we | -          | -
//
// Path: a character enters the input register, is decoded combinationally from it into
//   the result buffer once the buffer is free, and its first result shows on m_* as
//   soon as the buffer loads.
// Rate: one character per cycle while each yields at most one result and m_tready
//   stays high; a closing group of three bytes holds the result buffer until all three
//   have left, since the buffer has a single output port.
// Reset clears the group, the byte count, draining and both valid flags;
//   max_out_len returns to 65535.
// Stalls: s_tready drops only while the input register is full and the result
//   buffer cannot take the next item's results.
`default_nettype none

module base64_stream_decoder
  import b64d_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // slave stream: tdata = in_char[7:0]
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [CharW-1:0]    s_tdata,
  input  wire logic                s_tlast,
  // master stream: tdata = out_byte[7:0], msg_status[9:8], total_len[25:10], zero fill
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [OutDataW-1:0]      m_tdata,
  output logic                     m_tuser,   // byte_valid
  output logic                     m_tlast,   // run_last
  // configuration: max_out_len
  input  wire logic                cfg_we,
  input  wire logic [LenW-1:0]     cfg_wdata
);

  // Configuration register
  logic [LenW-1:0] max_out_len;

  // Input register
  logic             in_valid;
  logic [CharW-1:0] in_char;
  logic             in_last;

  // Message state
  logic [1:0]      sym_count;
  logic [SymW-1:0] held [3];
  logic            third_pad;
  logic [LenW-1:0] bytes_written;
  logic            draining;

  // Result buffer: up to three results of one item
  logic            buf_valid;
  logic [7:0]      buf_byte [3];
  logic            buf_has_bytes;
  logic [1:0]      buf_last_idx;
  logic [1:0]      buf_ptr;
  status_t         buf_status;
  logic [LenW-1:0] buf_len0;

  logic buf_free;
  logic advance;

  // Buffer is free when empty or its final result leaves in this cycle.
  assign buf_free = !buf_valid || (m_tready && (buf_ptr == buf_last_idx));
  assign advance  = in_valid && buf_free;
  assign s_tready = !in_valid || buf_free;

  // Decode of the item held in the input register
  logic [SymW:0]   sym;
  logic            sym_ok;
  logic            is_pad;
  logic [7:0]      dec_byte [3];
  logic [1:0]      cnt;
  logic [LenW-1:0] room;
  logic [1:0]      room_sat;
  logic [1:0]      emit;
  logic            close_group;
  status_t         status;
  logic [1:0]      n_res;
  logic [1:0]      sym_count_next;
  logic            third_pad_next;
  logic [LenW-1:0] bytes_written_next;
  logic            draining_next;

  always_comb begin
    sym         = sym_lookup(in_char);
    sym_ok      = !sym[SymW];
    is_pad      = (in_char == PadChar);
    close_group = !draining && sym_ok && (sym_count == 2'd3);

    dec_byte[0] = {held[0], held[1][5:4]};
    dec_byte[1] = {held[1][3:0], held[2][5:2]};
    dec_byte[2] = {held[2][1:0], sym[SymW-1:0]};

    cnt      = third_pad ? 2'd1 : (is_pad ? 2'd2 : 2'd3);
    room     = (bytes_written < max_out_len) ? (max_out_len - bytes_written) : '0;
    room_sat = (room >= LenW'(3)) ? 2'd3 : room[1:0];
    emit     = close_group ? ((cnt <= room_sat) ? cnt : room_sat) : 2'd0;

    sym_count_next     = sym_count;
    third_pad_next     = third_pad;
    bytes_written_next = bytes_written;
    draining_next      = draining;
    status             = ST_RUN;

    if (draining) begin
      // drop everything up to the item marked last
      if (in_last) begin
        draining_next      = 1'b0;
        sym_count_next     = '0;
        third_pad_next     = 1'b0;
        bytes_written_next = '0;
      end
    end else begin
      if (sym_ok) begin
        if (sym_count != 2'd3) begin
          if (sym_count == 2'd2) begin
            third_pad_next = is_pad;
          end
          sym_count_next = sym_count + 2'd1;
        end else begin
          sym_count_next     = '0;
          third_pad_next     = 1'b0;
          bytes_written_next = bytes_written + LenW'(emit);
          if (emit < cnt) begin
            status = ST_OVERFLOW;
          end else if (cnt != 2'd3) begin
            status = ST_OK;
          end
        end
      end
      if (status == ST_RUN && in_last) begin
        status = (sym_count_next != 2'd0) ? ST_INCOMPLETE : ST_OK;
      end
      if (status != ST_RUN) begin
        // any final status closes the message
        sym_count_next     = '0;
        third_pad_next     = 1'b0;
        bytes_written_next = '0;
        draining_next      = !in_last;
      end
    end

    if (emit != 2'd0) begin
      n_res = emit;
    end else if (status != ST_RUN) begin
      n_res = 2'd1;
    end else begin
      n_res = 2'd0;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_out_len <= MaxLenRst;
    end else if (cfg_we) begin
      max_out_len <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Message state
  always_ff @(posedge clk) begin
    if (rst) begin
      sym_count     <= '0;
      third_pad     <= 1'b0;
      bytes_written <= '0;
      draining      <= 1'b0;
    end else if (advance) begin
      sym_count     <= sym_count_next;
      third_pad     <= third_pad_next;
      bytes_written <= bytes_written_next;
      draining      <= draining_next;
    end
  end

  // Held symbols of the open group; no reset, each is written before it is read.
  always_ff @(posedge clk) begin
    if (advance && !draining && sym_ok && (sym_count != 2'd3)) begin
      held[sym_count] <= sym[SymW-1:0];
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      buf_ptr   <= '0;
    end else if (advance) begin
      buf_valid <= (n_res != 2'd0);
      buf_ptr   <= '0;
    end else if (buf_free) begin
      buf_valid <= 1'b0;
      buf_ptr   <= '0;
    end else if (m_tready) begin
      buf_ptr <= buf_ptr + 2'd1;
    end
  end

  // Result buffer payload
  always_ff @(posedge clk) begin
    if (advance) begin
      buf_byte      <= dec_byte;
      buf_has_bytes <= (emit != 2'd0);
      buf_last_idx  <= n_res - 2'd1;
      buf_status    <= status;
      buf_len0      <= bytes_written;
    end
  end

  // Present the result at buf_ptr
  logic            out_last;
  logic [7:0]      out_byte;
  logic [1:0]      out_status;
  logic [LenW-1:0] out_len;

  always_comb begin
    out_last   = (buf_ptr == buf_last_idx);
    out_byte   = buf_has_bytes ? buf_byte[buf_ptr] : 8'd0;
    out_status = out_last ? buf_status : ST_RUN;
    out_len    = buf_has_bytes ? (buf_len0 + LenW'(buf_ptr) + LenW'(1)) : buf_len0;
  end

  assign m_tvalid = buf_valid;
  assign m_tuser  = buf_has_bytes;
  assign m_tlast  = out_last;
  assign m_tdata  = {(OutDataW - 26)'(0), out_len, out_status, out_byte};

endmodule

`default_nettype wire

// ===== rtl/b64d_checker.sv =====
// Port-level checks for base64_stream_decoder, bound to the top level.
// Depends on b64d_pkg and the top level's ports.
`default_nettype none

module b64d_checker
  import b64d_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tuser,
  input wire logic        m_tlast
);

  // A result without a byte only carries a final status, so it ends its run.
  a_nobyte_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata[9:8] != ST_RUN))
    else $error("result without byte is not a final status");

  // A final status only appears on the last result of an item.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[9:8] != ST_RUN) |-> m_tlast)
    else $error("status on a result that is not last");

  // Status results carry a zero byte.
  a_nobyte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> (m_tdata[7:0] == 8'd0))
    else $error("nonzero byte without byte_valid");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for base64_stream_decoder: directed and random character streams.
// Predicts every result in-bench and checks it field by field as it leaves m_*.
// Depends on b64d_pkg and the RTL top level only.
module testbench;
  import b64d_pkg::*;

  // One decoded result as it travels on the master side.
  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic        run_end;
    status_t     st;
    logic [15:0] len;
  } dec_result_t;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdlePct    = 14;
  localparam int unsigned SettleCyc  = 8;
  localparam int unsigned RandGoal   = 150;
  localparam logic [6:0]  NotSymbol  = 7'h40;
  localparam logic [5:0]  SymPlus    = 6'd62;
  localparam logic [5:0]  SymSlash   = 6'd63;
  localparam logic [7:0]  PlusChar   = 8'h2B;
  localparam logic [7:0]  SlashChar  = 8'h2F;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [CharW-1:0]      s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OutDataW-1:0]   m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [LenW-1:0]       cfg_wdata = '0;

  // Mirror of the decoder state, advanced once per accepted character.
  logic [15:0]  lim_len = MaxLenRst;
  int           grp_cnt = 0;
  logic [5:0]   grp_sym [3];
  logic         grp_pad3 = 1'b0;
  int           msg_len = 0;
  logic         drain_mode = 1'b0;
  logic         item_used;

  dec_result_t  pending_results[$];
  int           mismatches = 0;
  int           checked = 0;
  int           used_items = 0;
  int unsigned  cycles = 0;
  logic         steady = 1'b0;   // 1: neither side idles

  base64_stream_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),    // in_char[7:0]
    .s_tlast   (s_tlast),    // end_of_input
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),    // out_byte[7:0], msg_status[9:8], total_len[25:10], zero fill
    .m_tuser   (m_tuser),    // byte_valid
    .m_tlast   (m_tlast),    // run_last
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)   // max_out_len
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Guard against a hung handshake or a lost result.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: stall at random unless in a steady stretch.
  always @(posedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(99) >= IdlePct);
  end

  // Map a character to {not_symbol, value}; '=' counts as value 0.
  function automatic logic [6:0] char_to_symbol(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return {1'b0, 6'(c - 8'h41)};          // A-Z
    if (c >= 8'h61 && c <= 8'h7A) return {1'b0, 6'(c - 8'h61 + 8'd26)};  // a-z
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, 6'(c - 8'h30 + 8'd52)};  // 0-9
    if (c == PlusChar) return {1'b0, SymPlus};
    if (c == SlashChar) return {1'b0, SymSlash};
    if (c == PadChar) return 7'd0;
    return NotSymbol;
  endfunction

  // Inverse direction for stimulus: value 0..63 to its alphabet character, 64 to '='.
  function automatic logic [7:0] symbol_char();
    int v;
    v = $urandom_range(64);
    if (v < 26) return 8'(8'h41 + v);
    if (v < 52) return 8'(8'h61 + v - 26);
    if (v < 62) return 8'(8'h30 + v - 52);
    if (v == 62) return PlusChar;
    if (v == 63) return SlashChar;
    return PadChar;
  endfunction

  function automatic logic [7:0] skip_char();
    logic [7:0] c;
    logic [6:0] s;
    do begin
      c = 8'($urandom_range(255));
      s = char_to_symbol(c);
    end while (!s[6]);
    return c;
  endfunction

  function automatic void clear_group();
    grp_cnt  = 0;
    grp_pad3 = 1'b0;
    msg_len  = 0;
  endfunction

  // Advance the mirror by one character and queue the results it causes.
  function automatic void predict_char(input logic [7:0] ch, input logic eoi);
    dec_result_t res [3];
    logic [6:0]  sym;
    logic [7:0]  grp_byte [3];
    int          n;
    int          cnt;
    int          room;
    int          emit;
    status_t     st;
    n = 0;
    st = ST_RUN;
    item_used = 1'b0;
    if (drain_mode) begin
      // Drop everything up to the character marked last.
      if (eoi) begin
        drain_mode = 1'b0;
        clear_group();
      end
      return;
    end
    sym = char_to_symbol(ch);
    item_used = !sym[6] || eoi;
    if (!sym[6]) begin
      if (grp_cnt < 3) begin
        grp_sym[grp_cnt] = sym[5:0];
        if (grp_cnt == 2) grp_pad3 = (ch == PadChar);
        grp_cnt++;
      end else begin
        // Fourth symbol closes the group: unpack 24 bits into up to three bytes.
        grp_byte[0] = {grp_sym[0], grp_sym[1][5:4]};
        grp_byte[1] = {grp_sym[1][3:0], grp_sym[2][5:2]};
        grp_byte[2] = {grp_sym[2][1:0], sym[5:0]};
        cnt  = grp_pad3 ? 1 : (ch == PadChar ? 2 : 3);
        room = (msg_len < int'(lim_len)) ? int'(lim_len) - msg_len : 0;
        emit = (cnt <= room) ? cnt : room;
        grp_cnt  = 0;
        grp_pad3 = 1'b0;
        for (int i = 0; i < emit; i++) begin
          msg_len++;
          res[n] = '{data: grp_byte[i], valid: 1'b1, run_end: 1'b0, st: ST_RUN,
                     len: 16'(msg_len)};
          n++;
        end
        // Overflow takes priority over a short (padded) group.
        if (emit < cnt) st = ST_OVERFLOW;
        else if (cnt < 3) st = ST_OK;
      end
    end
    if (st == ST_RUN && eoi) st = (grp_cnt != 0) ? ST_INCOMPLETE : ST_OK;
    if (st != ST_RUN) begin
      // Status rides on the last byte, or on an empty result if there is none.
      if (n == 0) begin
        res[0] = '{data: 8'd0, valid: 1'b0, run_end: 1'b0, st: st, len: 16'(msg_len)};
        n = 1;
      end else begin
        res[n-1].st = st;
      end
      clear_group();
      if (!eoi) drain_mode = 1'b1;
    end
    if (n > 0) res[n-1].run_end = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    mismatches++;
    $display("result %0d: %s got 0x%0h, want 0x%0h", checked, field, got, want);
  endtask

  // Result checker: compare each transaction on m_* with the oldest prediction.
  always @(posedge clk) begin
    dec_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, 0);
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[7:0] !== want.data) report_mismatch("out_byte", m_tdata[7:0], want.data);
        if (m_tdata[9:8] !== want.st) report_mismatch("msg_status", m_tdata[9:8], want.st);
        if (m_tdata[25:10] !== want.len)
          report_mismatch("total_len", m_tdata[25:10], want.len);
        if (m_tdata[31:26] !== 6'd0) report_mismatch("tdata fill", m_tdata[31:26], 0);
        if (m_tuser !== want.valid) report_mismatch("byte_valid", m_tuser, want.valid);
        if (m_tlast !== want.run_end) report_mismatch("run_last", m_tlast, want.run_end);
      end
      checked++;
    end
  end

  // Present one character, idling first at random, and hold until accepted.
  task automatic send_char(input logic [7:0] ch, input logic eoi);
    while (!steady && $urandom_range(99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= eoi;
    predict_char(ch, eoi);
    if (item_used) used_items++;
    do @(posedge clk); while (!s_tready);
  endtask

  // Send a string; mark its final character last when asked.
  task automatic send_text(input string txt, input logic mark_last);
    for (int i = 0; i < txt.len(); i++)
      send_char(8'(txt[i]), mark_last && (i == txt.len() - 1));
  endtask

  // Drop valid, wait for every predicted result, then let silent characters drain.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic set_max_len(input logic [15:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lim_len = value;
  endtask

  // Whole groups covering both ends of the alphabet and all-zero / all-one symbols.
  task automatic test_full_groups();
    send_text("+/Az", 1'b0);
    send_text("aZ09", 1'b1);
  endtask

  // Pad early in a group, skipped characters inside a group, padded end then drain.
  task automatic test_pad_and_skip();
    send_char(PadChar, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(PadChar, 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("QQ", 1'b0);
    send_text("TQ==", 1'b0);    // one byte, ends the message without last
    send_char(8'h78, 1'b0);     // dropped while draining
    send_char(8'h20, 1'b1);     // leaves draining, no result
  endtask

  // Message end on a skipped character, inside a group, and after a two-byte group.
  task automatic test_message_ends();
    send_char(8'h40, 1'b1);     // empty message ends ok with an empty result
    send_text("TW", 1'b1);      // incomplete
    send_text("TWE=", 1'b1);
  endtask

  // Limit reached: a padded group cut short, and nothing fits at all.
  task automatic test_overflow();
    set_max_len(16'd1);
    send_text("TWE=", 1'b1);
    set_max_len(16'd0);
    send_text("TWFu", 1'b0);    // overflow without last, then drain
    send_char(8'h51, 1'b1);
    set_max_len(16'hFFFF);
  endtask

  // Mostly well-formed messages with random content; the rest broken or noise.
  task automatic send_random_message();
    logic [8:0] seq [$];
    logic [8:0] tail;
    int         groups;
    int         ending;
    int         pads;
    ending = $urandom_range(9);
    groups = (ending == 7) ? $urandom_range(1, 4) : $urandom_range(0, 4);
    pads   = (ending == 7) ? $urandom_range(1, 2) : $urandom_range(0, 2);
    if (ending == 9) begin
      repeat ($urandom_range(1, 8)) seq.push_back({1'b0, 8'($urandom_range(255))});
    end else begin
      for (int g = 0; g < groups; g++) begin
        for (int k = 0; k < 4; k++) begin
          if ($urandom_range(9) == 0) seq.push_back({1'b0, skip_char()});
          if (g == groups - 1 && k >= 4 - pads) seq.push_back({1'b0, PadChar});
          else seq.push_back({1'b0, symbol_char()});
        end
      end
      if (ending == 5) seq.push_back({1'b0, skip_char()});
      if (ending == 6) repeat ($urandom_range(1, 3)) seq.push_back({1'b0, symbol_char()});
      if (ending == 7) repeat ($urandom_range(1, 4))
        seq.push_back({1'b0, 8'($urandom_range(255))});
    end
    if (seq.size() == 0) seq.push_back({1'b0, skip_char()});
    // Mark the end; open messages run on into the next one.
    if (ending != 8 && (ending != 9 || $urandom_range(1))) begin
      tail = seq.pop_back();
      seq.push_back({1'b1, tail[7:0]});
    end
    foreach (seq[i]) send_char(seq[i][7:0], seq[i][8]);
  endtask

  // Random traffic in three settings: steady at the reset limit, small limits, any limit.
  task automatic test_random_traffic();
    int goal;
    goal = used_items + RandGoal / 3;
    steady = 1'b1;
    while (used_items < goal) send_random_message();
    wait_drained();
    steady = 1'b0;
    goal = used_items + RandGoal / 3;
    set_max_len(16'($urandom_range(0, 9)));
    while (used_items < goal) begin
      send_random_message();
      if ($urandom_range(3) == 0) set_max_len(16'($urandom_range(0, 9)));
    end
    goal = used_items + RandGoal / 3;
    set_max_len(16'($urandom_range(65535)));
    while (used_items < goal) send_random_message();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_full_groups();
    test_pad_and_skip();
    test_message_ends();
    test_overflow();
    test_random_traffic();
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
